>>> hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication whose consequence is checked in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/hvr_pkg.sv
// ----------------------------------------------------------------------------
// hvr_pkg: types and constants of the Householder reflection block.
// Shared widths, the job descriptor between front and back, and the states.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hvr_pkg;

    localparam int ELEM_W    = 24;
    localparam int PROD_W    = 48;
    localparam int ACC_W     = 53;
    localparam int NUM_W     = 78;
    localparam int QUO_W     = 64;
    localparam int DEF_MAX_DIM = 16;

    localparam logic signed [ELEM_W-1:0] MAX_VAL = 24'sh7FFFFF;
    localparam logic signed [ELEM_W-1:0] MIN_VAL = -24'sh800000;

    typedef logic signed [ELEM_W-1:0] elem_t;
    typedef logic signed [ACC_W-1:0]  acc_t;

    typedef struct packed {
        acc_t dot;
        acc_t norm;
    } job_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_MUL,
        ST_MUL_HI,
        ST_DIV,
        ST_OUT
    } back_state_t;

endpackage

>>> hw/rtl/hvr_if.sv
// ----------------------------------------------------------------------------
// hvr_in_if / hvr_out_if: valid/ready channels of the reflection block.
// Each carries one element item of the input or result vector.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface hvr_in_if import hvr_pkg::*; ();
    logic  valid;
    logic  ready;
    elem_t x_elem;
    elem_t v_elem;
    logic  last_elem;
    modport source (output valid, x_elem, v_elem, last_elem, input ready);
    modport sink   (input valid, x_elem, v_elem, last_elem, output ready);
endinterface

interface hvr_out_if import hvr_pkg::*; ();
    logic  valid;
    logic  ready;
    elem_t out_value;
    logic  saturated;
    logic  copied;
    logic  last_out;
    modport source (output valid, out_value, saturated, copied, last_out, input ready);
    modport sink   (input valid, out_value, saturated, copied, last_out, output ready);
endinterface

>>> hw/rtl/householder_vector_reflect.sv
// ----------------------------------------------------------------------------
// householder_vector_reflect: Householder reflection of a fixed-point vector.
// Reflects x across the hyperplane normal to v, element by element.
// ----------------------------------------------------------------------------
// Usage: element pairs (x, v, last) enter on in_ch, one item per cycle while
// in_ch.ready is high. The vector closes on last or at MAX_DIM elements.
// Results leave on out_ch, one item per element, last_out on the final one.
// Each result passes through a memory read, a multiply in ST_MUL and
// ST_MUL_HI, the serial divider (78 quotient bits, then rounding), and the
// output load; the divider is the bottleneck. A copied vector (all-zero v)
// skips the divider: each element passes ST_READ, ST_MUL and ST_OUT.
// Two vectors of storage let the next vector load while the current one is
// being reflected; in_ch.ready drops when both are occupied.
// Reset clears all control state; storage needs no clearing.
// When out_ch stalls, the result register holds its item and the engine
// waits; the loader keeps accepting until both banks are full.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module householder_vector_reflect import hvr_pkg::*; #(
    parameter int MAX_DIM = DEF_MAX_DIM
) (
    input  logic       clk,
    input  logic       rst_n,
    hvr_in_if.sink     in_ch,
    hvr_out_if.source  out_ch
);

    localparam int IDX_W = $clog2(MAX_DIM + 1);

    logic             bank_free;
    logic             wr_en;
    logic             wr_bank;
    logic [IDX_W-1:0] wr_idx;
    logic             job_valid;
    job_t             job;
    logic [IDX_W-1:0] job_len;

    hvr_front #(.MAX_DIM(MAX_DIM), .IDX_W(IDX_W)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .x_elem    (in_ch.x_elem),
        .v_elem    (in_ch.v_elem),
        .last_elem (in_ch.last_elem),
        .bank_free (bank_free),
        .wr_en     (wr_en),
        .wr_bank   (wr_bank),
        .wr_idx    (wr_idx),
        .job_valid (job_valid),
        .job       (job),
        .job_len   (job_len)
    );

    hvr_back #(.MAX_DIM(MAX_DIM), .IDX_W(IDX_W)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (wr_en),
        .wr_bank   (wr_bank),
        .wr_idx    (wr_idx),
        .x_elem    (in_ch.x_elem),
        .v_elem    (in_ch.v_elem),
        .job_valid (job_valid),
        .job       (job),
        .job_len   (job_len),
        .bank_free (bank_free),
        .res       (out_ch)
    );

    `ASSERT_IMPL(a_job_needs_room, clk, rst_n, job_valid, bank_free, "job while queue full")
    `ASSERT_IMPL(a_copy_not_sat, clk, rst_n, out_ch.valid && out_ch.copied, !out_ch.saturated, "copied item flagged saturated")
    `ASSERT_IMPL(a_write_in_range, clk, rst_n, wr_en, wr_idx < IDX_W'(MAX_DIM), "element index out of range")

endmodule

>>> hw/rtl/hvr_front.sv
// ----------------------------------------------------------------------------
// hvr_front: element loader.
// Stores element pairs into one of two banks and accumulates v.x and v.v.
// On the closing element it hands a job to the back end through a queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hvr_front import hvr_pkg::*; #(
    parameter int MAX_DIM = DEF_MAX_DIM,
    parameter int IDX_W   = $clog2(MAX_DIM + 1)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  elem_t            x_elem,
    input  elem_t            v_elem,
    input  logic             last_elem,
    input  logic             bank_free,
    output logic             wr_en,
    output logic             wr_bank,
    output logic [IDX_W-1:0] wr_idx,
    output logic             job_valid,
    output job_t             job,
    output logic [IDX_W-1:0] job_len
);

    logic [IDX_W-1:0] count_reg, count_next;
    acc_t             dot_reg, dot_next;
    acc_t             norm_reg, norm_next;
    logic             bank_reg, bank_next;
    logic             fire;
    logic             close;
    acc_t             dot_sum;
    acc_t             norm_sum;

    assign in_ready  = bank_free;
    assign fire      = in_valid && in_ready;
    assign close     = last_elem || (count_reg == IDX_W'(MAX_DIM - 1));
    assign dot_sum   = dot_reg + ACC_W'(x_elem * v_elem);
    assign norm_sum  = norm_reg + ACC_W'(v_elem * v_elem);
    assign wr_en     = fire;
    assign wr_bank   = bank_reg;
    assign wr_idx    = count_reg;
    assign job_valid = fire && close;
    assign job.dot   = dot_sum;
    assign job.norm  = norm_sum;
    assign job_len   = count_reg + IDX_W'(1);

    always_comb
    begin
        count_next = count_reg;
        dot_next   = dot_reg;
        norm_next  = norm_reg;
        bank_next  = bank_reg;
        if (fire)
        begin
            if (close)
            begin
                count_next = '0;
                dot_next   = '0;
                norm_next  = '0;
                bank_next  = !bank_reg;
            end
            else
            begin
                count_next = count_reg + IDX_W'(1);
                dot_next   = dot_sum;
                norm_next  = norm_sum;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            dot_reg   <= '0;
            norm_reg  <= '0;
            bank_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            dot_reg   <= dot_next;
            norm_reg  <= norm_next;
            bank_reg  <= bank_next;
        end
    end

endmodule

>>> hw/rtl/hvr_divider.sv
// ----------------------------------------------------------------------------
// hvr_divider: restoring divider, one quotient bit per cycle.
// Divides a 78-bit magnitude by a 53-bit divisor, rounds half away from zero.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hvr_divider import hvr_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [NUM_W-1:0]  num,
    input  logic [ACC_W-1:0]  den,
    output logic              done,
    output logic [QUO_W-1:0]  quo
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] num_reg;
    logic [ACC_W-1:0] den_reg;
    logic [ACC_W:0]   rem_reg;
    logic [NUM_W-1:0] q_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [ACC_W+1:0] shifted;
    logic [ACC_W+1:0] diff;
    logic [NUM_W:0]   q_round;

    assign shifted = {rem_reg, num_reg[NUM_W-1]};
    assign diff    = shifted - {1'b0, 1'b0, den_reg};
    assign q_round = {1'b0, q_reg} + ({rem_reg, 1'b0} >= {2'b0, den_reg} ? 1'b1 : 1'b0);
    assign done    = done_reg;
    assign quo     = (q_round > (NUM_W+1)'(64'd1 << 40)) ? QUO_W'(64'd1 << 40)
                                                         : QUO_W'(q_round);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(NUM_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= num;
            den_reg <= den;
            rem_reg <= '0;
            q_reg   <= '0;
        end
        else if (busy_reg)
        begin
            num_reg <= {num_reg[NUM_W-2:0], 1'b0};
            if (!diff[ACC_W+1])
            begin
                rem_reg <= diff[ACC_W:0];
                q_reg   <= {q_reg[NUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= shifted[ACC_W:0];
                q_reg   <= {q_reg[NUM_W-2:0], 1'b0};
            end
        end
    end

endmodule

>>> hw/rtl/hvr_back.sv
// ----------------------------------------------------------------------------
// hvr_back: result engine.
// Takes jobs from a two-entry queue and computes each reflected element
// with a two-step multiply and the serial divider, or copies x when v is all zero.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hvr_back import hvr_pkg::*; #(
    parameter int MAX_DIM = DEF_MAX_DIM,
    parameter int IDX_W   = $clog2(MAX_DIM + 1),
    parameter int ADR_W   = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic             wr_bank,
    input  logic [IDX_W-1:0] wr_idx,
    input  elem_t            x_elem,
    input  elem_t            v_elem,
    input  logic             job_valid,
    input  job_t             job,
    input  logic [IDX_W-1:0] job_len,
    output logic             bank_free,
    hvr_out_if.source        res
);

    localparam int HALF_W = (ACC_W + 1) / 2;
    localparam int PART_W = HALF_W + ELEM_W;

    elem_t            x_mem [2**(ADR_W+1)];
    elem_t            v_mem [2**(ADR_W+1)];
    job_t             q_job [2];
    logic [IDX_W-1:0] q_len [2];
    logic [1:0]       q_cnt_reg;
    logic             q_rd_reg;
    logic             q_wr_reg;
    back_state_t      state_reg, state_next;
    logic [IDX_W-1:0] idx_reg;
    elem_t            xr_reg, vr_reg;
    logic [PART_W-1:0] part_reg;
    logic             neg_reg;
    logic             ob_valid_reg;
    elem_t            ob_value_reg;
    logic             ob_sat_reg, ob_cop_reg, ob_last_reg;
    job_t             cur_job;
    logic [IDX_W-1:0] cur_len;
    logic [ACC_W-1:0] dmag;
    logic [ACC_W:0]   dmag2;
    logic [ELEM_W-1:0] vmag;
    logic [PART_W-1:0] mul_hi;
    logic [NUM_W-1:0] div_num;
    logic             pop;
    logic             div_start, div_done;
    logic [QUO_W-1:0] quo;
    logic             is_copy;
    logic             is_last;
    logic signed [QUO_W:0] res_wide;
    elem_t            res_val;
    logic             res_sat;
    logic             load_out;

    assign cur_job   = q_job[q_rd_reg];
    assign cur_len   = q_len[q_rd_reg];
    assign bank_free = (q_cnt_reg != 2'd2);
    assign is_copy   = (cur_job.norm == '0);
    assign is_last   = (idx_reg + IDX_W'(1) == cur_len);
    assign dmag      = cur_job.dot[ACC_W-1] ? ACC_W'(-cur_job.dot) : ACC_W'(cur_job.dot);
    assign dmag2     = {dmag, 1'b0};
    assign vmag      = vr_reg[ELEM_W-1] ? ELEM_W'(-vr_reg) : ELEM_W'(vr_reg);
    assign mul_hi    = PART_W'(dmag2[ACC_W:HALF_W]) * PART_W'(vmag);
    assign div_num   = NUM_W'(part_reg) + (NUM_W'(mul_hi) << HALF_W);
    assign pop       = (state_reg == ST_OUT) && (state_next != ST_OUT) && is_last;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (q_cnt_reg != 2'd0) state_next = ST_READ;
            ST_READ:   state_next = ST_MUL;
            ST_MUL:    state_next = is_copy ? ST_OUT : ST_MUL_HI;
            ST_MUL_HI: state_next = ST_DIV;
            ST_DIV:    if (div_done) state_next = ST_OUT;
            ST_OUT:
            begin
                if (!ob_valid_reg || res.ready)
                    state_next = is_last ? ST_IDLE : ST_READ;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        div_start = 1'b0;
        load_out  = 1'b0;
        unique case (state_reg)
            ST_MUL_HI: div_start = 1'b1;
            ST_OUT:    load_out  = !ob_valid_reg || res.ready;
            default: ;
        endcase
    end

    hvr_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (cur_job.norm),
        .done  (div_done),
        .quo   (quo)
    );

    always_comb
    begin
        res_wide = neg_reg ? ((QUO_W+1)'(xr_reg) + (QUO_W+1)'(quo))
                           : ((QUO_W+1)'(xr_reg) - (QUO_W+1)'(quo));
        res_sat  = 1'b0;
        res_val  = ELEM_W'(res_wide);
        if (is_copy)
            res_val = xr_reg;
        else if (res_wide > (QUO_W+1)'(MAX_VAL))
        begin
            res_val = MAX_VAL;
            res_sat = 1'b1;
        end
        else if (res_wide < (QUO_W+1)'(MIN_VAL))
        begin
            res_val = MIN_VAL;
            res_sat = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            x_mem[{wr_bank, wr_idx[ADR_W-1:0]}] <= x_elem;
            v_mem[{wr_bank, wr_idx[ADR_W-1:0]}] <= v_elem;
        end
        if (state_reg == ST_READ)
        begin
            xr_reg <= x_mem[{q_rd_reg, idx_reg[ADR_W-1:0]}];
            vr_reg <= v_mem[{q_rd_reg, idx_reg[ADR_W-1:0]}];
        end
        if (state_reg == ST_MUL)
        begin
            part_reg <= PART_W'(dmag2[HALF_W-1:0]) * PART_W'(vmag);
            neg_reg  <= cur_job.dot[ACC_W-1] ^ vr_reg[ELEM_W-1];
        end
        if (job_valid)
        begin
            q_job[q_wr_reg] <= job;
            q_len[q_wr_reg] <= job_len;
        end
        if (load_out)
        begin
            ob_value_reg <= res_val;
            ob_sat_reg   <= res_sat;
            ob_cop_reg   <= is_copy;
            ob_last_reg  <= is_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            idx_reg      <= '0;
            q_cnt_reg    <= '0;
            q_rd_reg     <= 1'b0;
            q_wr_reg     <= 1'b0;
            ob_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_OUT && state_next != ST_OUT)
                idx_reg <= is_last ? '0 : idx_reg + IDX_W'(1);
            if (job_valid)
                q_wr_reg <= !q_wr_reg;
            if (pop)
                q_rd_reg <= !q_rd_reg;
            q_cnt_reg <= q_cnt_reg + (job_valid ? 2'd1 : 2'd0) - (pop ? 2'd1 : 2'd0);
            if (load_out)
                ob_valid_reg <= 1'b1;
            else if (res.ready)
                ob_valid_reg <= 1'b0;
        end
    end

    assign res.valid     = ob_valid_reg;
    assign res.out_value = ob_value_reg;
    assign res.saturated = ob_sat_reg;
    assign res.copied    = ob_cop_reg;
    assign res.last_out  = ob_last_reg;

endmodule
